// File: rtl/hss_pkg.sv
// Shared constants, codes, types and hue helper for the HSL saturation scaler.
package hss_pkg;

  // Component format: code / CMAX
  localparam int CB = 16;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam int FRAC_BITS = 30;
  localparam logic [FRAC_BITS:0] ONE_Q = 31'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_Q = 31'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] SAT_FLOOR = 31'd1073742;
  localparam logic [15:0] GAIN_RESET = 16'd16384;

  // Divider geometry: saturation and the three ramps
  localparam int SDIV_NUM_BITS = 48;
  localparam int DIV_DEN_BITS = 16;
  localparam int SDIV_QUO_BITS = 31;
  localparam int RDIV_NUM_BITS = 48;
  localparam int RDIV_QUO_BITS = 32;

  // Hue segment codes
  localparam logic [1:0] SEG_UP   = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_DOWN = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  typedef struct packed {
    logic [1:0]  seg;
    logic [15:0] f;
  } seg_t;

  // Fields that ride along the saturation divider
  typedef struct packed {
    logic [15:0] delta;
    logic [18:0] hn;
    logic        sum_lt;
    logic [15:0] lc;
    logic        gray;
    logic [30:0] l;
    logic [15:0] alpha;
    logic        last;
  } side1_t;

  // Fields that ride along the ramp dividers
  typedef struct packed {
    logic signed [33:0] p;
    logic signed [33:0] q;
    logic [5:0]  segs;
    logic        flat;
    logic [15:0] lc;
    logic [15:0] alpha;
    logic        last;
  } side2_t;

  // Pick the hue segment of one channel and its ramp numerator
  function automatic seg_t hue_seg(input logic [18:0] hn, input logic [15:0] dl,
                                   input int ch);
    logic signed [21:0] dl_s;
    logic signed [21:0] tn;
    logic signed [21:0] down;
    seg_t r;
    dl_s = $signed({6'b0, dl});
    case (ch)
      0: tn = $signed({3'b0, hn}) + (dl_s <<< 1);
      1: tn = $signed({3'b0, hn});
      default: tn = $signed({3'b0, hn}) - (dl_s <<< 1);
    endcase
    if (tn < 0) tn = tn + dl_s * 22'sd6;
    if (tn > dl_s * 22'sd6) tn = tn - dl_s * 22'sd6;
    down = (dl_s <<< 2) - tn;
    if (tn < dl_s) begin
      r.seg = SEG_UP;
      r.f = tn[15:0];
    end else if (tn < dl_s * 22'sd3) begin
      r.seg = SEG_HIGH;
      r.f = '0;
    end else if (tn < (dl_s <<< 2)) begin
      r.seg = SEG_DOWN;
      r.f = down[15:0];
    end else begin
      r.seg = SEG_LOW;
      r.f = '0;
    end
    return r;
  endfunction

endpackage

// File: rtl/hsl_saturation_scaler.sv
// HSL saturation scaler top level: a deep pipeline, one pixel per cycle unless stalled.
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   red_in green_in blue_in alpha_in last_pixel_in
//   output    out_valid  out_stall  red_out green_out blue_out alpha_out last_pixel_out
//   config    saturation_gain_we    saturation_gain_wdata
//
// One request enters per cycle while the output is not stalled; the pipeline
// is the 31-stage saturation divider and the 32-stage ramp dividers plus eight
// arithmetic stages. rst (synchronous) empties the pipeline and loads gain 1.0.
// A stalled output freezes the whole pipeline; in_stall follows out_stall
// while a result is waiting, so nothing is lost or repeated.
module hsl_saturation_scaler
  import hss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        saturation_gain_we,
  input  logic [15:0] saturation_gain_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] alpha_in,
  input  logic        last_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic [15:0] alpha_out,
  output logic        last_pixel_out
);

  localparam int L1 = SDIV_QUO_BITS;
  localparam int L2 = RDIV_QUO_BITS;

  logic        en;
  logic [15:0] saturation_gain;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Hold the gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_gain <= GAIN_RESET;
    end else if (saturation_gain_we) begin
      saturation_gain <= saturation_gain_wdata;
    end
  end

  // Stage A: max, min, sum, delta and hue numerator
  logic        a_valid;
  logic [16:0] a_sum;
  logic [15:0] a_delta;
  logic [18:0] a_hn;
  logic [15:0] a_alpha;
  logic        a_last;

  logic [15:0] mx, mn;
  logic signed [19:0] hn_raw;
  logic signed [19:0] dl20;
  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx) mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    dl20 = $signed({4'b0, mx - mn});
    if (mx == red_in) begin
      hn_raw = $signed({4'b0, green_in}) - $signed({4'b0, blue_in});
    end else if (mx == green_in) begin
      hn_raw = (dl20 <<< 1) + $signed({4'b0, blue_in}) - $signed({4'b0, red_in});
    end else begin
      hn_raw = (dl20 <<< 2) + $signed({4'b0, red_in}) - $signed({4'b0, green_in});
    end
    if (hn_raw < 0) hn_raw = hn_raw + dl20 * 20'sd6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum   <= {1'b0, mx} + {1'b0, mn};
      a_delta <= mx - mn;
      a_hn    <= hn_raw[18:0];
      a_alpha <= alpha_in;
      a_last  <= last_pixel_in;
    end
  end

  // Stage B: divider numerator and denominator, lightness
  logic                     b_valid;
  logic [SDIV_NUM_BITS-1:0] b_snum;
  logic [15:0]              b_den;
  side1_t                   b_side;

  logic [16:0] den_wide;
  logic [15:0] den;
  assign den_wide = (a_sum <= {1'b0, CMAX}) ? a_sum : ({CMAX, 1'b0} - a_sum);
  assign den      = den_wide[15:0];

  // Fold sum * 2^29 + CMAX/2 by 16-bit digits to divide it by CMAX
  logic [30:0] lt1;
  logic [16:0] lt2;
  logic [30:0] l_next;
  assign lt1    = {1'b0, a_sum, 13'b0} + 31'd32767;
  assign lt2    = {2'b0, lt1[30:16]} + {1'b0, lt1[15:0]};
  assign l_next = {1'b0, a_sum, 13'b0} + 31'(lt1[30:16]) + 31'(lt2 >= {1'b0, CMAX});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_snum        <= {32'(a_delta) * 32'(saturation_gain), 16'b0}
                       + SDIV_NUM_BITS'(den >> 1);
      b_den         <= den;
      b_side.delta  <= a_delta;
      b_side.hn     <= a_hn;
      b_side.sum_lt <= (a_sum < {1'b0, CMAX});
      b_side.lc     <= 16'((a_sum + 17'd1) >> 1);
      b_side.gray   <= (a_delta == '0);
      b_side.l      <= l_next;
      b_side.alpha  <= a_alpha;
      b_side.last   <= a_last;
    end
  end

  // Saturation divider
  logic [SDIV_QUO_BITS-1:0] s_quo;
  logic                     s_over;

  hss_divider #(
    .NUM_BITS(SDIV_NUM_BITS), .DEN_BITS(DIV_DEN_BITS), .QUO_BITS(SDIV_QUO_BITS)
  ) u_sdiv (
    .clk(clk), .en(en), .num(b_snum), .den(b_den), .quo(s_quo), .over(s_over)
  );

  // Delay the side fields along the divider
  logic [L1-1:0] v1;
  side1_t        d1 [L1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
    end else if (en) begin
      v1 <= {v1[L1-2:0], b_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= b_side;
      for (int i = 1; i < L1; i++) begin
        d1[i] <= d1[i-1];
      end
    end
  end

  // Stage C: clamp saturation, flag flat pixels
  logic         c_valid;
  logic [30:0]  c_s, c_l;
  logic         c_flat;
  side1_t       c_side;
  logic [30:0]  s_clamped;

  assign s_clamped = (s_over || (s_quo > ONE_Q)) ? ONE_Q : s_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= v1[L1-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s    <= s_clamped;
      c_l    <= d1[L1-1].l;
      c_flat <= d1[L1-1].gray || (s_clamped < SAT_FLOOR);
      c_side <= d1[L1-1];
    end
  end

  // Stage D: ls = round(l * s)
  logic        d_valid;
  logic [30:0] d_s, d_l, d_ls;
  logic        d_flat;
  side1_t      d_side;
  logic [61:0] ls_wide;

  assign ls_wide = c_l * c_s + 62'(HALF_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s    <= c_s;
      d_l    <= c_l;
      d_ls   <= ls_wide[60:30];
      d_flat <= c_flat;
      d_side <= c_side;
    end
  end

  // Stage E: q, p, d and the hue segment of each channel
  logic               e_valid;
  logic signed [33:0] e_p, e_q;
  logic [31:0]        e_d;
  seg_t               e_seg [3];
  logic               e_flat;
  side1_t             e_side;

  logic signed [33:0] l_s, s_s, ls_s, q_n, p_n, dd_n;
  always_comb begin
    l_s  = $signed({3'b0, d_l});
    s_s  = $signed({3'b0, d_s});
    ls_s = $signed({3'b0, d_ls});
    q_n  = d_side.sum_lt ? (l_s + ls_s) : (l_s + s_s - ls_s);
    p_n  = (l_s <<< 1) - q_n;
    dd_n = q_n - p_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_p    <= p_n;
      e_q    <= q_n;
      e_d    <= dd_n[33] ? 32'd0 : dd_n[31:0];
      for (int j = 0; j < 3; j++) begin
        e_seg[j] <= hue_seg(d_side.hn, d_side.delta, j);
      end
      e_flat <= d_flat;
      e_side <= d_side;
    end
  end

  // Stage F: ramp numerators
  logic                     f_valid;
  logic [RDIV_NUM_BITS-1:0] f_num [3];
  logic [15:0]              f_delta;
  side2_t                   f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        f_num[j] <= e_d * e_seg[j].f + RDIV_NUM_BITS'(e_side.delta >> 1);
      end
      f_delta      <= e_side.delta;
      f_side.p     <= e_p;
      f_side.q     <= e_q;
      f_side.segs  <= {e_seg[2].seg, e_seg[1].seg, e_seg[0].seg};
      f_side.flat  <= e_flat;
      f_side.lc    <= e_side.lc;
      f_side.alpha <= e_side.alpha;
      f_side.last  <= e_side.last;
    end
  end

  // Ramp dividers, one per channel
  logic [RDIV_QUO_BITS-1:0] r_quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_ramp
    hss_divider #(
      .NUM_BITS(RDIV_NUM_BITS), .DEN_BITS(DIV_DEN_BITS), .QUO_BITS(RDIV_QUO_BITS)
    ) u_rdiv (
      .clk(clk), .en(en), .num(f_num[j]), .den(f_delta), .quo(r_quo[j]), .over()
    );
  end

  logic [L2-1:0] v2;
  side2_t        d2 [L2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= '0;
    end else if (en) begin
      v2 <= {v2[L2-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= f_side;
      for (int i = 1; i < L2; i++) begin
        d2[i] <= d2[i-1];
      end
    end
  end

  // Stage G: select the segment value and clamp to 0..1
  logic        g_valid;
  logic [30:0] g_v [3];
  logic        g_flat;
  logic [15:0] g_lc, g_alpha;
  logic        g_last;

  logic signed [34:0] sel_v [3];
  logic [30:0]        clamp_v [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      case (d2[L2-1].segs[2*j +: 2])
        SEG_HIGH: sel_v[j] = 35'(d2[L2-1].q);
        SEG_LOW:  sel_v[j] = 35'(d2[L2-1].p);
        default:  sel_v[j] = 35'(d2[L2-1].p) + $signed({3'b0, r_quo[j]});
      endcase
      if (sel_v[j] < 0) begin
        clamp_v[j] = '0;
      end else if (sel_v[j] > $signed({4'b0, ONE_Q})) begin
        clamp_v[j] = ONE_Q;
      end else begin
        clamp_v[j] = sel_v[j][30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= v2[L2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        g_v[j] <= clamp_v[j];
      end
      g_flat  <= d2[L2-1].flat;
      g_lc    <= d2[L2-1].lc;
      g_alpha <= d2[L2-1].alpha;
      g_last  <= d2[L2-1].last;
    end
  end

  // Stage H: convert to component codes and drive the outputs
  logic [46:0] comp_w [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      comp_w[j] = {g_v[j], 16'b0} - 47'(g_v[j]) + 47'(HALF_Q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out        <= g_flat ? g_lc : comp_w[0][45:30];
      green_out      <= g_flat ? g_lc : comp_w[1][45:30];
      blue_out       <= g_flat ? g_lc : comp_w[2][45:30];
      alpha_out      <= g_alpha;
      last_pixel_out <= g_last;
    end
  end

  // An accepted request shows up in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> a_valid)
    else $error("accepted request missing from stage A");

  // Clamped saturation never exceeds one
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> c_s <= ONE_Q)
    else $error("saturation above one");

  // q is never negative on colored pixels
  a_q_positive: assert property (@(posedge clk) disable iff (rst)
    e_valid && !e_flat |-> !e_q[33])
    else $error("negative q");

  // A frozen pipeline keeps its stage G
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(g_valid) && $stable(g_lc))
    else $error("stage G moved during stall");

endmodule

// File: rtl/hss_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module hss_divider
  import hss_pkg::*;
#(
  parameter int NUM_BITS = SDIV_NUM_BITS,
  parameter int DEN_BITS = DIV_DEN_BITS,
  parameter int QUO_BITS = SDIV_QUO_BITS
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [QUO_BITS-1:0] quo,
  output logic                over
);

  localparam int WW = ((NUM_BITS > DEN_BITS + QUO_BITS) ? NUM_BITS : DEN_BITS + QUO_BITS) + 1;

  logic [WW-1:0]       rem  [QUO_BITS];
  logic [DEN_BITS-1:0] dv   [QUO_BITS];
  logic [QUO_BITS-1:0] qv   [QUO_BITS];
  logic                ov   [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    logic [WW-1:0]       rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [QUO_BITS-1:0] q_in;
    logic                ov_in;
    logic [WW-1:0]       trial;

    if (i == 0) begin : g_first
      // flag quotients that do not fit
      assign rem_in = WW'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign ov_in  = (WW'(num) >= (WW'(den) << QUO_BITS));
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign den_in = dv[i-1];
      assign q_in   = qv[i-1];
      assign ov_in  = ov[i-1];
    end

    assign trial = WW'(den_in) << (QUO_BITS - 1 - i);

    // resolve one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[i] <= rem_in - trial;
          qv[i]  <= q_in | (QUO_BITS'(1) << (QUO_BITS - 1 - i));
        end else begin
          rem[i] <= rem_in;
          qv[i]  <= q_in;
        end
        dv[i] <= den_in;
        ov[i] <= ov_in;
      end
    end
  end

  assign quo  = qv[QUO_BITS-1];
  assign over = ov[QUO_BITS-1];

endmodule
